[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the DAC address sequencer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[src/dacseq_pkg.sv]
// ----------------------------------------------------------------------------
// dacseq_pkg
// Types, codes and the operation table of the DAC address sequencer.
// ----------------------------------------------------------------------------
package dacseq_pkg;

    // Request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_PROG = 2'd2;

    localparam logic [5:0]  PHASE_IDLE     = 6'd0;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd500;

    // Bus operation kinds
    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_START   = 3'd1,
        K_SEND    = 3'd2,
        K_ACK     = 3'd3,
        K_RESTART = 3'd4,
        K_GET     = 3'd5,
        K_NACK    = 3'd6,
        K_STOP    = 3'd7
    } kind_t;

    // Sequencer state
    typedef struct packed {
        logic [5:0]  phase;     // {step, sub-phase}
        logic        is_prog;
        logic [3:0]  bit_idx;
        logic [7:0]  shift;
        logic [15:0] wait_cnt;
        logic [3:0]  err;
        logic [2:0]  addr_now;
        logic [2:0]  addr_next;
        logic [2:0]  drives;    // bit0 SDA, bit1 SCL, bit2 LDAC
    } seq_state_t;

    // One result transaction
    typedef struct packed {
        logic       sda_low;
        logic       scl_low;
        logic       ldac_low;
        logic       busy_res;
        logic       done_res;
        logic [3:0] error_mask;
        logic [2:0] found_address;
    } seq_res_t;

    // Operation performed at each step of the read and program sequences
    function automatic kind_t kind_of(input logic is_prog, input logic [3:0] step);
        kind_t k;
        k = K_NONE;
        if (is_prog) begin
            case (step)
                4'd1:                    k = K_START;
                4'd2, 4'd4, 4'd6, 4'd8:  k = K_SEND;
                4'd3, 4'd5, 4'd7, 4'd9:  k = K_ACK;
                4'd10:                   k = K_STOP;
                default:                 k = K_NONE;
            endcase
        end else begin
            case (step)
                4'd1:              k = K_START;
                4'd2, 4'd4, 4'd7:  k = K_SEND;
                4'd3, 4'd5, 4'd8:  k = K_ACK;
                4'd6:              k = K_RESTART;
                4'd9:              k = K_GET;
                4'd10:             k = K_NACK;
                4'd11:             k = K_STOP;
                default:           k = K_NONE;
            endcase
        end
        return k;
    endfunction

endpackage

[src/dac_address_i2c_sequencer.sv]
// ----------------------------------------------------------------------------
// dac_address_i2c_sequencer
// Open-drain I2C master that reads back or reprograms a DAC bus address.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick and yields exactly one result
// transaction. A tick passes through an input register, one pass of the
// sequencer step logic, and a result register, so a new tick is taken every
// clock while results flow out. Bus timing is counted in ticks, not clocks:
// each bus phase lasts half_period_ticks ticks (0 acts as 1), so the host sets
// the bus rate by how often it sends ticks. Requests arriving while busy are
// ignored.
// The half period register may be written only while no tick is in flight.
module dac_address_i2c_sequencer
(
    input  logic        clk,
    input  logic        rst_n,
    // tick input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  current_address,
    input  logic [2:0]  new_address,
    input  logic        sda_in,
    input  logic        scl_in,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        sda_low,
    output logic        scl_low,
    output logic        ldac_low,
    output logic        busy_res,
    output logic        done_res,
    output logic [3:0]  error_mask,
    output logic [2:0]  found_address,
    // half period register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                   in_valid_reg;
    logic [1:0]             req_type_reg;
    logic [2:0]             current_address_reg;
    logic [2:0]             new_address_reg;
    logic                   sda_in_reg;
    logic                   scl_in_reg;
    logic                   out_valid_reg;
    dacseq_pkg::seq_res_t   out_res_reg;
    dacseq_pkg::seq_res_t   res_next;
    dacseq_pkg::seq_state_t state_reg;
    dacseq_pkg::seq_state_t state_next;
    logic [15:0]            half_period_reg;
    logic                   advance;

    // Pipeline control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            half_period_reg <= dacseq_pkg::HALF_PERIOD_RST;
        end else if (cfg_valid) begin
            half_period_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            req_type_reg        <= req_type;
            current_address_reg <= current_address;
            new_address_reg     <= new_address;
            sda_in_reg          <= sda_in;
            scl_in_reg          <= scl_in;
        end
    end

    // Step logic
    dacseq_step u_step
    (
        .cur             (state_reg),
        .req_type        (req_type_reg),
        .current_address (current_address_reg),
        .new_address     (new_address_reg),
        .sda_in          (sda_in_reg),
        .scl_in          (scl_in_reg),
        .half_period     (half_period_reg),
        .nxt             (state_next),
        .res             (res_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sda_low       = out_res_reg.sda_low;
    assign scl_low       = out_res_reg.scl_low;
    assign ldac_low      = out_res_reg.ldac_low;
    assign busy_res      = out_res_reg.busy_res;
    assign done_res      = out_res_reg.done_res;
    assign error_mask    = out_res_reg.error_mask;
    assign found_address = out_res_reg.found_address;

endmodule

[src/dacseq_step.sv]
// ----------------------------------------------------------------------------
// dacseq_step
// Next-state and result logic for one tick of the I2C address sequencer.
// ----------------------------------------------------------------------------
module dacseq_step
(
    input  dacseq_pkg::seq_state_t cur,
    input  logic [1:0]             req_type,
    input  logic [2:0]             current_address,
    input  logic [2:0]             new_address,
    input  logic                   sda_in,
    input  logic                   scl_in,
    input  logic [15:0]            half_period,
    output dacseq_pkg::seq_state_t nxt,
    output dacseq_pkg::seq_res_t   res
);

    // Steps with special meaning
    localparam logic [3:0] STEP_FIRST     = 4'd1;
    localparam logic [3:0] STEP_BYTE0     = 4'd2;
    localparam logic [3:0] STEP_ACK0      = 4'd3;
    localparam logic [3:0] STEP_BYTE1     = 4'd4;
    localparam logic [3:0] STEP_ACK1      = 4'd5;
    localparam logic [3:0] STEP_BYTE2     = 4'd6;
    localparam logic [3:0] STEP_ACK2      = 4'd7;
    localparam logic [3:0] STEP_ACK2_READ = 4'd8;
    localparam logic [3:0] STEP_ACK3_PROG = 4'd9;

    // Pin drives (1 pulls low) for a given operation and sub-phase: {ldac, scl, sda}
    function automatic logic [2:0] drives_for(input dacseq_pkg::kind_t k,
                                              input logic [1:0] sb,
                                              input logic msb,
                                              input logic ldac);
        logic sda;
        logic scl;
        sda = 1'b0;
        scl = 1'b0;
        case (k)
            dacseq_pkg::K_START:
            begin
                sda = 1'b1;
                scl = (sb != 2'd0);
            end
            dacseq_pkg::K_SEND:
            begin
                sda = ~msb;
                scl = (sb == 2'd0);
            end
            dacseq_pkg::K_ACK, dacseq_pkg::K_GET, dacseq_pkg::K_NACK:
            begin
                scl = (sb == 2'd0);
            end
            dacseq_pkg::K_RESTART:
            begin
                sda = sb[1];
                scl = (sb == 2'd0) || (sb == 2'd3);
            end
            dacseq_pkg::K_STOP:
            begin
                sda = ~sb[1];
                scl = (sb == 2'd0);
            end
            default:
            begin
                sda = 1'b0;
                scl = 1'b0;
            end
        endcase
        return {ldac, scl, sda};
    endfunction

    // Byte sent at a given step
    function automatic logic [7:0] byte_for(input logic prog, input logic [3:0] st,
                                            input logic [2:0] a_now,
                                            input logic [2:0] a_new);
        logic [7:0] b;
        if (prog) begin
            if (st == STEP_BYTE0)      b = 8'hC0 | {4'd0, a_now, 1'b0};
            else if (st == STEP_BYTE1) b = 8'h61 | {3'd0, a_now, 2'd0};
            else if (st == STEP_BYTE2) b = 8'h62 | {3'd0, a_new, 2'd0};
            else                       b = 8'h63 | {3'd0, a_new, 2'd0};
        end else begin
            if (st == STEP_BYTE0)      b = 8'h00;
            else if (st == STEP_BYTE1) b = 8'h0C;
            else                       b = 8'hC1;
        end
        return b;
    endfunction

    // Error bit flagged by a missing acknowledge
    function automatic logic [3:0] ack_bit(input logic prog, input logic [3:0] st);
        logic [3:0] m;
        if (st == STEP_ACK0)                            m = 4'b1000;
        else if (st == STEP_ACK1)                       m = 4'b0100;
        else if (st == STEP_ACK2 || (!prog && st == STEP_ACK2_READ)) m = 4'b0010;
        else                                            m = 4'b0001;
        return m;
    endfunction

    logic [15:0]       hp;
    logic [16:0]       wait_n;
    logic [3:0]        step;
    logic [1:0]        sub;
    dacseq_pkg::kind_t k;
    logic [3:0]        bit_n;
    logic              go_next;
    logic              go_enter;
    logic              go_idle;
    logic [3:0]        enter_step;
    logic [1:0]        enter_sub;
    logic [3:0]        nstep;
    dacseq_pkg::kind_t kn;
    logic              done;
    logic              check_bad;

    // Tick evaluation
    always_comb
    begin
        nxt        = cur;
        done       = 1'b0;
        go_next    = 1'b0;
        go_enter   = 1'b0;
        go_idle    = 1'b0;
        hp         = (half_period == 16'd0) ? 16'd1 : half_period;
        wait_n     = {1'b0, cur.wait_cnt} + 17'd1;
        step       = cur.phase[5:2];
        sub        = cur.phase[1:0];
        k          = dacseq_pkg::kind_of(cur.is_prog, step);
        bit_n      = cur.bit_idx + 4'd1;
        enter_step = step;
        enter_sub  = 2'd0;
        nstep      = step + 4'd1;
        kn         = dacseq_pkg::K_NONE;
        check_bad  = (cur.shift[7:5] != cur.shift[3:1]) ||
                     ((cur.shift & 8'h11) != 8'h10);

        if (cur.phase == dacseq_pkg::PHASE_IDLE) begin
            // New request
            if (req_type == dacseq_pkg::REQ_READ || req_type == dacseq_pkg::REQ_PROG) begin
                nxt.is_prog   = (req_type == dacseq_pkg::REQ_PROG);
                nxt.addr_now  = current_address;
                nxt.addr_next = new_address;
                nxt.err       = 4'd0;
                nxt.bit_idx   = 4'd0;
                nxt.shift     = 8'd0;
                nxt.drives    = 3'd0;
                go_enter      = 1'b1;
                enter_step    = STEP_FIRST;
            end
        end else if (wait_n < {1'b0, hp}) begin
            nxt.wait_cnt = wait_n[15:0];
        end else begin
            // Phase end
            case (k)
                dacseq_pkg::K_START, dacseq_pkg::K_NACK:
                begin
                    if (sub == 2'd0) begin
                        go_enter  = 1'b1;
                        enter_sub = 2'd1;
                    end else begin
                        go_next = 1'b1;
                    end
                end
                dacseq_pkg::K_SEND:
                begin
                    if (sub == 2'd0) begin
                        go_enter  = 1'b1;
                        enter_sub = 2'd1;
                    end else begin
                        nxt.shift   = {cur.shift[6:0], 1'b0};
                        nxt.bit_idx = bit_n;
                        if (bit_n[3]) go_next  = 1'b1;
                        else          go_enter = 1'b1;
                    end
                end
                dacseq_pkg::K_ACK:
                begin
                    if (sub == 2'd0) begin
                        go_enter  = 1'b1;
                        enter_sub = 2'd1;
                    end else begin
                        if (sda_in) nxt.err = cur.err | ack_bit(cur.is_prog, step);
                        go_next = 1'b1;
                    end
                end
                dacseq_pkg::K_RESTART:
                begin
                    if (sub != 2'd3) begin
                        go_enter  = 1'b1;
                        enter_sub = sub + 2'd1;
                    end else begin
                        go_next = 1'b1;
                    end
                end
                dacseq_pkg::K_GET:
                begin
                    if (sub == 2'd0) begin
                        go_enter  = 1'b1;
                        enter_sub = 2'd1;
                    end else if (!scl_in) begin
                        // slave stretching the clock: retry next tick
                        nxt.wait_cnt = hp - 16'd1;
                    end else begin
                        nxt.shift   = {cur.shift[6:0], sda_in};
                        nxt.bit_idx = bit_n;
                        if (bit_n[3]) go_next  = 1'b1;
                        else          go_enter = 1'b1;
                    end
                end
                dacseq_pkg::K_STOP:
                begin
                    if (sub[1] == 1'b0) begin
                        go_enter  = 1'b1;
                        enter_sub = sub + 2'd1;
                    end else begin
                        if (!cur.is_prog && check_bad) nxt.err = cur.err | 4'b0001;
                        go_idle = 1'b1;
                        done    = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase
        end

        // Advance to the next bus operation
        if (go_next) begin
            kn          = dacseq_pkg::kind_of(nxt.is_prog, nstep);
            nxt.bit_idx = 4'd0;
            if (kn == dacseq_pkg::K_SEND)
                nxt.shift = byte_for(nxt.is_prog, nstep, nxt.addr_now, nxt.addr_next);
            if (kn == dacseq_pkg::K_GET)
                nxt.shift = 8'd0;
            if (kn == dacseq_pkg::K_ACK) begin
                if (nstep == STEP_ACK1) nxt.drives[2] = 1'b1;
                if ((nxt.is_prog && nstep == STEP_ACK3_PROG) ||
                    (!nxt.is_prog && nstep == STEP_ACK2_READ))
                    nxt.drives[2] = 1'b0;
            end
            go_enter   = 1'b1;
            enter_step = nstep;
            enter_sub  = 2'd0;
        end

        // Enter a sub-phase
        if (go_enter) begin
            nxt.phase    = {enter_step, enter_sub};
            nxt.wait_cnt = 16'd0;
            nxt.drives   = drives_for(dacseq_pkg::kind_of(nxt.is_prog, enter_step),
                                      enter_sub, nxt.shift[7], nxt.drives[2]);
        end

        if (go_idle) begin
            nxt.phase    = dacseq_pkg::PHASE_IDLE;
            nxt.wait_cnt = 16'd0;
            nxt.drives   = 3'd0;
        end
    end

    // Result of this tick
    always_comb
    begin
        res.sda_low       = nxt.drives[0];
        res.scl_low       = nxt.drives[1];
        res.ldac_low      = nxt.drives[2];
        res.busy_res      = (nxt.phase != dacseq_pkg::PHASE_IDLE);
        res.done_res      = done;
        res.error_mask    = nxt.err;
        res.found_address = (done && !nxt.is_prog && nxt.err == 4'd0) ?
                            nxt.shift[7:5] : 3'd0;
    end

endmodule

[src/dacseq_checker.sv]
// ----------------------------------------------------------------------------
// dacseq_checker
// Port-level checks for the DAC address sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dacseq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic [2:0]  current_address,
    input logic [2:0]  new_address,
    input logic        sda_in,
    input logic        scl_in,
    input logic        out_valid,
    input logic        out_ready,
    input logic        sda_low,
    input logic        scl_low,
    input logic        ldac_low,
    input logic        busy_res,
    input logic        done_res,
    input logic [3:0]  error_mask,
    input logic [2:0]  found_address,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [15:0] cfg_data
);

    // Stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({sda_low, scl_low, ldac_low, busy_res, done_res, error_mask, found_address}))

    // Finishing tick ends the sequence
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid && done_res, !busy_res)

    // Idle bus leaves every pin released
    `ASSERT_IMPLY(a_idle_released, clk, rst_n, out_valid && !busy_res, !sda_low && !scl_low && !ldac_low)

    // Address only reported on a clean finish
    `ASSERT_IMPLY(a_found_clean, clk, rst_n, out_valid && found_address != 3'd0, done_res && error_mask == 4'd0)

endmodule

bind dac_address_i2c_sequencer dacseq_checker u_dacseq_checker (.*);

[dv/dac_address_i2c_sequencer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_address_i2c_sequencer_test
// Self-checking bench for the DAC address sequencer. A table of directed
// ticks runs first, then random ticks at several half-period settings. The
// random ticks answer acks and the read-back byte the way a device would,
// apart from some noisy sequences. Each result is compared with a table row
// or a tick-level prediction of pin drives, status and read-back address.
// ----------------------------------------------------------------------------
module dac_address_i2c_sequencer_test;
    import dacseq_pkg::*;

    // Request code with no meaning, ignored like a plain tick
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Error mask bits, first ack to last ack / read-back check
    localparam logic [3:0] ERR_ACK_FIRST  = 4'b1000;
    localparam logic [3:0] ERR_ACK_SECOND = 4'b0100;
    localparam logic [3:0] ERR_ACK_THIRD  = 4'b0010;
    localparam logic [3:0] ERR_LAST       = 4'b0001;

    // Bytes on the bus
    localparam logic [7:0] RD_GENERAL_CALL = 8'h00;
    localparam logic [7:0] RD_ADDR_CMD     = 8'h0C;
    localparam logic [7:0] RD_DEVICE_RD    = 8'hC1;
    localparam logic [7:0] PG_DEVICE_WR    = 8'hC0;
    localparam logic [7:0] PG_OLD_ADDR     = 8'h61;
    localparam logic [7:0] PG_NEW_ADDR     = 8'h62;
    localparam logic [7:0] PG_CONFIRM      = 8'h63;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;
    localparam int TAIL_CYCLES    = 10;

    // Bus operation at each position of the two sequences
    localparam kind_t READ_PLAN [16] = '{K_NONE, K_START, K_SEND, K_ACK, K_SEND, K_ACK,
        K_RESTART, K_SEND, K_ACK, K_GET, K_NACK, K_STOP, K_NONE, K_NONE, K_NONE, K_NONE};
    localparam kind_t PROG_PLAN [16] = '{K_NONE, K_START, K_SEND, K_ACK, K_SEND, K_ACK,
        K_SEND, K_ACK, K_SEND, K_ACK, K_STOP, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE};

    // Half-period settings of the random part and the ticks sent at each
    localparam logic [15:0] HALF_PLAN [6] = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd1};
    localparam int COUNT_PLAN [6] = '{200, 300, 200, 30, 100, 120};

    typedef struct packed {
        logic [1:0] req;
        logic [2:0] cur;
        logic [2:0] nxt;
        logic       sda;
        logic       scl;
    } tick_t;

    typedef struct packed {
        logic     typed;
        tick_t    tick;
        seq_res_t res;
    } dir_row_t;

    localparam seq_res_t RES_QUIET = '0;
    localparam seq_res_t RES_START = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0, 3'd0};

    // Directed ticks at the reset half period; a start only shows its first phase
    localparam dir_row_t DIR_ROWS [12] = '{
        '{1'b1, '{REQ_TICK,  3'd0, 3'd0, 1'b0, 1'b0}, RES_QUIET},
        '{1'b1, '{REQ_SPARE, 3'd7, 3'd7, 1'b1, 1'b1}, RES_QUIET},
        '{1'b1, '{REQ_TICK,  3'd7, 3'd0, 1'b1, 1'b0}, RES_QUIET},
        '{1'b1, '{REQ_READ,  3'd7, 3'd7, 1'b1, 1'b1}, RES_START},
        '{1'b1, '{REQ_PROG,  3'd0, 3'd7, 1'b0, 1'b0}, RES_START},
        '{1'b1, '{REQ_SPARE, 3'd5, 3'd2, 1'b1, 1'b1}, RES_START},
        '{1'b1, '{REQ_READ,  3'd0, 3'd0, 1'b0, 1'b1}, RES_START},
        '{1'b0, '{REQ_TICK,  3'd2, 3'd5, 1'b1, 1'b0}, RES_QUIET},
        '{1'b0, '{REQ_PROG,  3'd6, 3'd1, 1'b0, 1'b1}, RES_QUIET},
        '{1'b0, '{REQ_TICK,  3'd1, 3'd6, 1'b1, 1'b1}, RES_QUIET},
        '{1'b0, '{REQ_SPARE, 3'd4, 3'd3, 1'b0, 1'b0}, RES_QUIET},
        '{1'b0, '{REQ_READ,  3'd3, 3'd2, 1'b1, 1'b0}, RES_QUIET}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [2:0]  current_address;
    logic [2:0]  new_address;
    logic        sda_in;
    logic        scl_in;
    logic        out_valid;
    logic        out_ready;
    logic        sda_low;
    logic        scl_low;
    logic        ldac_low;
    logic        busy_res;
    logic        done_res;
    logic [3:0]  error_mask;
    logic [2:0]  found_address;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Predicted sequencer state
    logic [5:0]  bus_phase;
    logic        prog_op;
    logic [3:0]  bit_cnt;
    logic [7:0]  data_sr;
    int          tick_cnt;
    logic [3:0]  ack_err;
    logic [2:0]  addr_cur;
    logic [2:0]  addr_new;
    logic [2:0]  pin_low;     // bit0 SDA, bit1 SCL, bit2 LDAC
    logic [15:0] half_ticks;

    seq_res_t bus_levels_q[$];
    int       bad_cnt;
    int       quiet_cycles;
    bit       hold_off;

    dac_address_i2c_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .current_address (current_address),
        .new_address     (new_address),
        .sda_in          (sda_in),
        .scl_in          (scl_in),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .sda_low         (sda_low),
        .scl_low         (scl_low),
        .ldac_low        (ldac_low),
        .busy_res        (busy_res),
        .done_res        (done_res),
        .error_mask      (error_mask),
        .found_address   (found_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sequencer prediction
    // ------------------------------------------------------------------
    function automatic kind_t op_at(input logic [3:0] pos);
        return prog_op ? PROG_PLAN[pos] : READ_PLAN[pos];
    endfunction

    function automatic logic [7:0] byte_at(input logic [3:0] pos);
        logic [7:0] b;
        if (prog_op)
        begin
            case (pos)
                4'd2:    b = PG_DEVICE_WR | {4'b0, addr_cur, 1'b0};
                4'd4:    b = PG_OLD_ADDR  | {3'b0, addr_cur, 2'b0};
                4'd6:    b = PG_NEW_ADDR  | {3'b0, addr_new, 2'b0};
                default: b = PG_CONFIRM   | {3'b0, addr_new, 2'b0};
            endcase
        end
        else
        begin
            case (pos)
                4'd2:    b = RD_GENERAL_CALL;
                4'd4:    b = RD_ADDR_CMD;
                default: b = RD_DEVICE_RD;
            endcase
        end
        return b;
    endfunction

    function automatic logic [3:0] ack_flag(input logic [3:0] pos);
        if (pos == 4'd3)
            return ERR_ACK_FIRST;
        if (pos == 4'd5)
            return ERR_ACK_SECOND;
        if (pos == 4'd7 || (!prog_op && pos == 4'd8))
            return ERR_ACK_THIRD;
        return ERR_LAST;
    endfunction

    // New phase: SDA and SCL drives change at once, LDAC is kept
    function automatic void phase_enter(input logic [3:0] pos, input logic [1:0] sub);
        logic sda_l;
        logic scl_l;
        sda_l = 1'b0;
        scl_l = 1'b0;
        bus_phase = {pos, sub};
        tick_cnt = 0;
        case (op_at(pos))
            K_START:
            begin
                sda_l = 1'b1;
                scl_l = (sub != 2'd0);
            end
            K_SEND:
            begin
                sda_l = ~data_sr[7];
                scl_l = (sub == 2'd0);
            end
            K_ACK, K_GET, K_NACK:
                scl_l = (sub == 2'd0);
            K_RESTART:
            begin
                sda_l = (sub >= 2'd2);
                scl_l = (sub == 2'd0 || sub == 2'd3);
            end
            K_STOP:
            begin
                sda_l = (sub < 2'd2);
                scl_l = (sub == 2'd0);
            end
            default: ;
        endcase
        pin_low = {pin_low[2], scl_l, sda_l};
    endfunction

    // Move on to the next bus operation; LDAC falls at the second ack
    function automatic void advance_op(input logic [3:0] pos);
        logic [3:0] nx;
        kind_t      k;
        nx = pos + 4'd1;
        k = op_at(nx);
        bit_cnt = '0;
        if (k == K_SEND)
            data_sr = byte_at(nx);
        if (k == K_GET)
            data_sr = '0;
        if (k == K_ACK)
        begin
            if (nx == 4'd5)
                pin_low[2] = 1'b1;
            if ((prog_op && nx == 4'd9) || (!prog_op && nx == 4'd8))
                pin_low[2] = 1'b0;
        end
        phase_enter(nx, 2'd0);
    endfunction

    // End of a phase, returns 1 when the sequence completes
    function automatic logic phase_close(input logic sda_i, input logic scl_i, input int hp);
        logic [3:0] pos;
        logic [1:0] sub;
        logic       fin;
        pos = bus_phase[5:2];
        sub = bus_phase[1:0];
        fin = 1'b0;
        case (op_at(pos))
            K_START, K_NACK:
            begin
                if (sub == 2'd0)
                    phase_enter(pos, 2'd1);
                else
                    advance_op(pos);
            end
            K_SEND:
            begin
                if (sub == 2'd0)
                    phase_enter(pos, 2'd1);
                else
                begin
                    data_sr = {data_sr[6:0], 1'b0};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        advance_op(pos);
                    else
                        phase_enter(pos, 2'd0);
                end
            end
            K_ACK:
            begin
                if (sub == 2'd0)
                    phase_enter(pos, 2'd1);
                else
                begin
                    if (sda_i)
                        ack_err = ack_err | ack_flag(pos);
                    advance_op(pos);
                end
            end
            K_RESTART:
            begin
                if (sub < 2'd3)
                    phase_enter(pos, sub + 2'd1);
                else
                    advance_op(pos);
            end
            K_GET:
            begin
                if (sub == 2'd0)
                    phase_enter(pos, 2'd1);
                else if (!scl_i)
                    tick_cnt = hp - 1;    // device stretches the clock
                else
                begin
                    data_sr = {data_sr[6:0], sda_i};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        advance_op(pos);
                    else
                        phase_enter(pos, 2'd0);
                end
            end
            K_STOP:
            begin
                if (sub < 2'd2)
                    phase_enter(pos, sub + 2'd1);
                else
                begin
                    // read-back must hold the address twice, bit 4 set, bit 0 clear
                    if (!prog_op && (data_sr[7:5] != data_sr[3:1] || !data_sr[4] || data_sr[0]))
                        ack_err = ack_err | ERR_LAST;
                    bus_phase = PHASE_IDLE;
                    tick_cnt = 0;
                    pin_low = '0;
                    fin = 1'b1;
                end
            end
            default:
            begin
                bus_phase = PHASE_IDLE;
                tick_cnt = 0;
                pin_low = '0;
            end
        endcase
        return fin;
    endfunction

    // One tick through the sequencer
    function automatic seq_res_t bus_step(input tick_t t);
        seq_res_t r;
        logic     fin;
        int       hp;
        hp = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
        fin = 1'b0;
        if (bus_phase == PHASE_IDLE)
        begin
            if (t.req == REQ_READ || t.req == REQ_PROG)
            begin
                prog_op = (t.req == REQ_PROG);
                addr_cur = t.cur;
                addr_new = t.nxt;
                ack_err = '0;
                bit_cnt = '0;
                data_sr = '0;
                pin_low = '0;
                phase_enter(4'd1, 2'd0);
            end
        end
        else
        begin
            tick_cnt = tick_cnt + 1;
            if (tick_cnt >= hp)
                fin = phase_close(t.sda, t.scl, hp);
        end
        r.sda_low = pin_low[0];
        r.scl_low = pin_low[1];
        r.ldac_low = pin_low[2];
        r.busy_res = (bus_phase != PHASE_IDLE);
        r.done_res = fin;
        r.error_mask = ack_err;
        r.found_address = (fin && !prog_op && ack_err == 4'd0) ? data_sr[7:5] : 3'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_tick(input tick_t t, input logic typed, input seq_res_t typed_res);
        seq_res_t pred;
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= t.req;
        current_address <= t.cur;
        new_address <= t.nxt;
        sda_in <= t.sda;
        scl_in <= t.scl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = bus_step(t);
        bus_levels_q.push_back(typed ? typed_res : pred);
    endtask

    // Stop offering ticks and wait for every outstanding result
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bus_levels_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_half_period(input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        half_ticks = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        tick_t      t;
        kind_t      kd;
        int         hp_eff;
        logic       smp;
        logic       seq_clean;
        logic [7:0] rd_byte;
        logic [2:0] a;
        int         sent;
        int         burst;
        int         gap;

        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        current_address = '0;
        new_address = '0;
        sda_in = 1'b0;
        scl_in = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        bus_phase = PHASE_IDLE;
        prog_op = 1'b0;
        bit_cnt = '0;
        data_sr = '0;
        tick_cnt = 0;
        ack_err = '0;
        addr_cur = '0;
        addr_new = '0;
        pin_low = '0;
        half_ticks = HALF_PERIOD_RST;
        seq_clean = 1'b1;
        rd_byte = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < 12; i++)
            send_tick(DIR_ROWS[i].tick, DIR_ROWS[i].typed, DIR_ROWS[i].res);

        // random ticks, one block per half-period setting
        for (int p = 0; p < 6; p++)
        begin
            settle();
            write_half_period(HALF_PLAN[p]);
            sent = 0;
            while (sent < COUNT_PLAN[p])
            begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                for (int b = 0; b < burst && sent < COUNT_PLAN[p]; b++)
                begin
                    t.req = 2'($urandom_range(0, 3));
                    t.cur = 3'($urandom_range(0, 7));
                    t.nxt = 3'($urandom_range(0, 7));
                    t.sda = 1'($urandom_range(0, 1));
                    t.scl = 1'($urandom_range(0, 1));
                    kd = op_at(bus_phase[5:2]);
                    hp_eff = (half_ticks == 16'd0) ? 1 : int'(half_ticks);
                    // this tick ends the second half of an ack or data bit
                    smp = (bus_phase != PHASE_IDLE) && (tick_cnt + 1 >= hp_eff)
                          && (bus_phase[1:0] != 2'd0);
                    if (bus_phase == PHASE_IDLE)
                    begin
                        if ($urandom_range(0, 7) != 0)
                            t.req = $urandom_range(0, 1) ? REQ_PROG : REQ_READ;
                        if (t.req == REQ_READ || t.req == REQ_PROG)
                        begin
                            // mostly well-behaved devices, some noisy ones
                            seq_clean = ($urandom_range(0, 4) != 0);
                            a = 3'($urandom_range(0, 7));
                            rd_byte = seq_clean ? {a, 1'b1, a, 1'b0} : 8'($urandom);
                        end
                    end
                    else if (smp && kd == K_ACK)
                        t.sda = seq_clean ? 1'b0 : 1'($urandom_range(0, 1));
                    else if (smp && kd == K_GET)
                    begin
                        t.scl = ($urandom_range(0, 3) != 0);
                        t.sda = rd_byte[3'd7 - bit_cnt[2:0]];
                    end
                    send_tick(t, 1'b0, RES_QUIET);
                    sent++;
                    if (p == 1 && sent == 100)
                        hold_off = 1'b1;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_cnt == 0 && bus_levels_q.size() == 0)
            $display("dac_address_i2c_sequencer_test: PASS");
        else
            $display("dac_address_i2c_sequencer_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random stall chunks plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int chunk;
        int stall_pct;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            chunk = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 50;
                default: stall_pct = 80;
            endcase
            repeat (chunk)
            begin
                @(negedge clk);
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        seq_res_t got;
        seq_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {sda_low, scl_low, ldac_low, busy_res, done_res, error_mask, found_address};
            if (bus_levels_q.size() == 0)
            begin
                bad_cnt++;
                if (bad_cnt <= MAX_REPORTS)
                    $display("%0t: result transaction with nothing pending: %h", $realtime, got);
            end
            else
            begin
                want = bus_levels_q.pop_front();
                if (got !== want)
                begin
                    bad_cnt++;
                    if (bad_cnt <= MAX_REPORTS)
                        $display({"%0t: mismatch exp/act sda %b/%b scl %b/%b ldac %b/%b",
                                  " busy %b/%b done %b/%b err %h/%h found %0d/%0d"},
                                 $realtime, want.sda_low, got.sda_low, want.scl_low,
                                 got.scl_low, want.ldac_low, got.ldac_low, want.busy_res,
                                 got.busy_res, want.done_res, got.done_res, want.error_mask,
                                 got.error_mask, want.found_address, got.found_address);
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("dac_address_i2c_sequencer_test: FAIL");
            $finish;
        end
    end

endmodule
